// ===== hdl/sitd_pkg.sv =====
package sitd_pkg;

    // Widths of the number path.
    localparam int NUM_W   = 32;
    localparam int WIDE_W  = 34;
    localparam int POS_W   = 4;
    localparam int CHAR_W  = 8;

    // Highest decimal position of a 32-bit magnitude (ten digits).
    localparam logic [POS_W-1:0] MAX_POS = 4'd9;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Depth of the queue between front and back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    // One classified number as it travels from front to back.
    typedef struct packed {
        logic              neg;
        logic [NUM_W-1:0]  mag;
        logic [POS_W-1:0]  top_pos;
    } sitd_item_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        B_IDLE,
        B_SIGN,
        B_DIGIT
    } sitd_state_t;

    // Powers of ten, wide enough to hold ten to the tenth.
    function automatic logic [WIDE_W-1:0] pow10(input logic [POS_W-1:0] k);
        logic [WIDE_W-1:0] r;
        begin
            case (k)
                4'd0:    r = 34'd1;
                4'd1:    r = 34'd10;
                4'd2:    r = 34'd100;
                4'd3:    r = 34'd1000;
                4'd4:    r = 34'd10000;
                4'd5:    r = 34'd100000;
                4'd6:    r = 34'd1000000;
                4'd7:    r = 34'd10000000;
                4'd8:    r = 34'd100000000;
                4'd9:    r = 34'd1000000000;
                4'd10:   r = 34'd10000000000;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hdl/sitd_front.sv =====
module sitd_front import sitd_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [NUM_W-1:0]    value,
    output logic                item_valid,
    output sitd_item_t          item,
    input  logic                item_full
);

    logic               valid_reg;
    logic               valid_next;
    logic               neg_reg;
    logic [NUM_W-1:0]   mag_reg;
    logic               take;
    logic               leave;
    logic [POS_W-1:0]   top_pos;

    // The held word moves on whenever the queue has room, so a new word may enter the same cycle.
    assign leave = valid_reg && !item_full;
    assign full  = valid_reg && item_full;
    assign take  = push && !full;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (leave)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Sign and magnitude are formed on entry; the most negative value wraps to its unsigned magnitude.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            neg_reg <= value[NUM_W-1];
            mag_reg <= value[NUM_W-1] ? (NUM_W'(0) - value) : value;
        end
    end

    // The index of the leading digit is the number of powers of ten, from ten upward, not above the magnitude.
    always_comb
    begin
        top_pos = '0;
        for (int k = 1; k <= int'(MAX_POS); k++)
        begin
            if ({2'b00, mag_reg} >= pow10(POS_W'(k)))
            begin
                top_pos = top_pos + 1'b1;
            end
        end
    end

    assign item_valid   = leave;
    assign item.neg     = neg_reg;
    assign item.mag     = mag_reg;
    assign item.top_pos = top_pos;

endmodule

// ===== hdl/sitd_fifo.sv =====
module sitd_fifo import sitd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  sitd_item_t  wr_item,
    output logic        fifo_full,
    input  logic        rd_en,
    output sitd_item_t  rd_item,
    output logic        fifo_empty
);

    sitd_item_t                 slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]      wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]      wr_ptr_next;
    logic [FIFO_PTR_W-1:0]      rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]      rd_ptr_next;
    logic [FIFO_CNT_W-1:0]      count_reg;
    logic [FIFO_CNT_W-1:0]      count_next;
    logic                       do_wr;
    logic                       do_rd;

    assign fifo_full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign fifo_empty = (count_reg == '0);
    assign do_wr      = wr_en && !fifo_full;
    assign do_rd      = rd_en && !fifo_empty;
    assign rd_item    = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== hdl/sitd_back.sv =====
module sitd_back import sitd_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  sitd_item_t          head,
    input  logic                head_empty,
    output logic                head_pop,
    output logic                empty,
    input  logic                pop,
    output logic [CHAR_W-1:0]   char_code,
    output logic                final_char
);

    sitd_state_t            state_reg;
    sitd_state_t            state_next;
    logic [NUM_W-1:0]       mag_reg;
    logic [NUM_W-1:0]       mag_next;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CHAR_W-1:0]      out_char_reg;
    logic                   out_final_reg;
    logic                   out_free;
    logic                   emit;
    logic [CHAR_W-1:0]      emit_char;
    logic                   emit_final;
    logic                   load;
    logic [WIDE_W-1:0]      base;
    logic [WIDE_W-1:0]      prod [10];
    logic [POS_W-1:0]       digit;
    logic [WIDE_W-1:0]      rest;

    // The output word register is free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || pop;

    // Digit at the current position: count the multiples of the place value that fit.
    always_comb
    begin
        base  = pow10(pos_reg);
        digit = '0;
        for (int i = 0; i < 10; i++)
        begin
            prod[i] = base * WIDE_W'(i);
        end
        for (int i = 1; i < 10; i++)
        begin
            if ({2'b00, mag_reg} >= prod[i])
            begin
                digit = digit + 1'b1;
            end
        end
        rest = {2'b00, mag_reg} - prod[digit];
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!head_empty)
                begin
                    state_next = head.neg ? B_SIGN : B_DIGIT;
                end
            end
            B_SIGN:
            begin
                if (out_free)
                begin
                    state_next = B_DIGIT;
                end
            end
            B_DIGIT:
            begin
                if (out_free && (pos_reg == '0))
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Output and datapath control.
    always_comb
    begin
        head_pop   = 1'b0;
        load       = 1'b0;
        emit       = 1'b0;
        emit_char  = CHAR_ZERO;
        emit_final = 1'b0;
        mag_next   = mag_reg;
        pos_next   = pos_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!head_empty)
                begin
                    head_pop = 1'b1;
                    load     = 1'b1;
                    mag_next = head.mag;
                    pos_next = head.top_pos;
                end
            end
            B_SIGN:
            begin
                emit      = out_free;
                emit_char = CHAR_MINUS;
            end
            B_DIGIT:
            begin
                emit       = out_free;
                load       = out_free;
                emit_char  = CHAR_ZERO + {4'b0000, digit};
                emit_final = (pos_reg == '0);
                mag_next   = rest[NUM_W-1:0];
                pos_next   = pos_reg - 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working number and output word.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mag_reg <= mag_next;
            pos_reg <= pos_next;
        end
        if (emit)
        begin
            out_char_reg  <= emit_char;
            out_final_reg <= emit_final;
        end
    end

    assign empty      = !out_valid_reg;
    assign char_code  = out_char_reg;
    assign final_char = out_final_reg;

    // The remaining magnitude always fits below the next place value.
    a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIGIT) |-> ({2'b00, mag_reg} < pow10(pos_reg + 1'b1)))
        else $error("magnitude exceeds the current digit position");

    // A minus sign is never the last character of a number.
    a_sign_not_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_char_reg == CHAR_MINUS)) |-> !out_final_reg)
        else $error("minus sign marked as final");

    // Emitting the units digit ends the number.
    a_units_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIGIT && out_free && pos_reg == '0) |=>
        (state_reg == B_IDLE && out_valid_reg && out_final_reg))
        else $error("units digit did not close the number");

    // The back end takes a new number only when idle.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> (state_reg == B_IDLE && !head_empty))
        else $error("queue read outside idle");

endmodule

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// Channel   Direction  Handshake            Fields
// input     in         push / full          value[31:0] signed
// result    out        pop / empty          char_code[7:0], final_char
//
// Each number is loaded by the back end while idle and then sent one
// character per cycle while the result word is free; the digit unit sets
// this rate. The front registers each word and a two-word queue decouples
// it from the back. Reset clears the front stage, queue and sequencer; a
// stalled pop holds the result word and lets the queue fill to its depth.
module signed_int_to_decimal_ascii import sitd_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [NUM_W-1:0]    value,
    output logic                empty,
    input  logic                pop,
    output logic [CHAR_W-1:0]   char_code,
    output logic                final_char
);

    logic           item_valid;
    sitd_item_t     item;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    sitd_item_t     q_head;

    // Front: sign, magnitude and leading-digit position.
    sitd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .value      (value),
        .item_valid (item_valid),
        .item       (item),
        .item_full  (q_full)
    );

    // Queue between front and back.
    sitd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (item_valid),
        .wr_item    (item),
        .fifo_full  (q_full),
        .rd_en      (q_pop),
        .rd_item    (q_head),
        .fifo_empty (q_empty)
    );

    // Back: character sequencer and output word register.
    sitd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_empty (q_empty),
        .head_pop   (q_pop),
        .empty      (empty),
        .pop        (pop),
        .char_code  (char_code),
        .final_char (final_char)
    );

endmodule
